>>> rtl/core/rtnh_pkg.sv
package rtnh_pkg;

	localparam int COORD_W_DEF = 32;
	localparam int DIST_W      = 31;
	localparam int QUOT_W      = 32;
	localparam int IN_W        = 32;

	// det floor, 1e-8 in units of 2^-48
	localparam logic [21:0] DET_MIN = 22'd2814750;
	// t floor, about 1e-4 in Q16.16
	localparam logic [DIST_W-1:0] T_MIN  = 31'd7;
	localparam logic [DIST_W-1:0] T_ONES = 31'h7FFF_FFFF;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	// operand vectors: narrow ones live in the vector file, PV and QV are cross products
	typedef enum logic [2:0] {
		V_DIR = 3'd0,
		V_E1  = 3'd1,
		V_E2  = 3'd2,
		V_TV  = 3'd3,
		V_PV  = 3'd4,
		V_QV  = 3'd5
	} vsrc_t;

	typedef enum logic [3:0] {
		D_NONE, D_PV0, D_PV1, D_PV2, D_QV0, D_QV1, D_QV2, D_DET, D_UN, D_VN, D_TN
	} dest_t;

	// one multiply-accumulate step of the sequence
	typedef struct packed {
		vsrc_t       wsel;
		logic [1:0]  wi;
		vsrc_t       msel;
		logic [1:0]  mi;
		logic        sub;
		logic        first;
		logic        last;
		dest_t       dest;
	} op_t;

	// control into the serial multiply-accumulate unit
	typedef struct packed {
		logic start;
		logic clear;
		logic negate;
	} mac_ctl_t;

	localparam int NUM_OPS = 24;
	localparam logic [4:0] LAST_OP   = 5'd23;
	localparam logic [4:0] FIRST_DOT_NEG = 5'd15;

	function automatic op_t mk_op(vsrc_t w, logic [1:0] wi, vsrc_t m, logic [1:0] mi,
			logic sub, logic first, logic last, dest_t dest);
		op_t o;
		o.wsel  = w;
		o.wi    = wi;
		o.msel  = m;
		o.mi    = mi;
		o.sub   = sub;
		o.first = first;
		o.last  = last;
		o.dest  = dest;
		return o;
	endfunction

	// pv = dir x e2, qv = tv x e1, then det, u, v and t dot products
	function automatic op_t op_decode(logic [4:0] op);
		op_t o;
		o = mk_op(V_DIR, 2'd0, V_DIR, 2'd0, 1'b0, 1'b0, 1'b0, D_NONE);
		unique case (op)
			5'd0:  o = mk_op(V_DIR, 2'd1, V_E2, 2'd2, 1'b0, 1'b1, 1'b0, D_NONE);
			5'd1:  o = mk_op(V_DIR, 2'd2, V_E2, 2'd1, 1'b1, 1'b0, 1'b1, D_PV0);
			5'd2:  o = mk_op(V_DIR, 2'd2, V_E2, 2'd0, 1'b0, 1'b1, 1'b0, D_NONE);
			5'd3:  o = mk_op(V_DIR, 2'd0, V_E2, 2'd2, 1'b1, 1'b0, 1'b1, D_PV1);
			5'd4:  o = mk_op(V_DIR, 2'd0, V_E2, 2'd1, 1'b0, 1'b1, 1'b0, D_NONE);
			5'd5:  o = mk_op(V_DIR, 2'd1, V_E2, 2'd0, 1'b1, 1'b0, 1'b1, D_PV2);
			5'd6:  o = mk_op(V_TV,  2'd1, V_E1, 2'd2, 1'b0, 1'b1, 1'b0, D_NONE);
			5'd7:  o = mk_op(V_TV,  2'd2, V_E1, 2'd1, 1'b1, 1'b0, 1'b1, D_QV0);
			5'd8:  o = mk_op(V_TV,  2'd2, V_E1, 2'd0, 1'b0, 1'b1, 1'b0, D_NONE);
			5'd9:  o = mk_op(V_TV,  2'd0, V_E1, 2'd2, 1'b1, 1'b0, 1'b1, D_QV1);
			5'd10: o = mk_op(V_TV,  2'd0, V_E1, 2'd1, 1'b0, 1'b1, 1'b0, D_NONE);
			5'd11: o = mk_op(V_TV,  2'd1, V_E1, 2'd0, 1'b1, 1'b0, 1'b1, D_QV2);
			5'd12: o = mk_op(V_PV,  2'd0, V_E1, 2'd0, 1'b0, 1'b1, 1'b0, D_NONE);
			5'd13: o = mk_op(V_PV,  2'd1, V_E1, 2'd1, 1'b0, 1'b0, 1'b0, D_NONE);
			5'd14: o = mk_op(V_PV,  2'd2, V_E1, 2'd2, 1'b0, 1'b0, 1'b1, D_DET);
			5'd15: o = mk_op(V_PV,  2'd0, V_TV, 2'd0, 1'b0, 1'b1, 1'b0, D_NONE);
			5'd16: o = mk_op(V_PV,  2'd1, V_TV, 2'd1, 1'b0, 1'b0, 1'b0, D_NONE);
			5'd17: o = mk_op(V_PV,  2'd2, V_TV, 2'd2, 1'b0, 1'b0, 1'b1, D_UN);
			5'd18: o = mk_op(V_QV,  2'd0, V_DIR, 2'd0, 1'b0, 1'b1, 1'b0, D_NONE);
			5'd19: o = mk_op(V_QV,  2'd1, V_DIR, 2'd1, 1'b0, 1'b0, 1'b0, D_NONE);
			5'd20: o = mk_op(V_QV,  2'd2, V_DIR, 2'd2, 1'b0, 1'b0, 1'b1, D_VN);
			5'd21: o = mk_op(V_QV,  2'd0, V_E2, 2'd0, 1'b0, 1'b1, 1'b0, D_NONE);
			5'd22: o = mk_op(V_QV,  2'd1, V_E2, 2'd1, 1'b0, 1'b0, 1'b0, D_NONE);
			5'd23: o = mk_op(V_QV,  2'd2, V_E2, 2'd2, 1'b0, 1'b0, 1'b1, D_TN);
			default: o = mk_op(V_DIR, 2'd0, V_DIR, 2'd0, 1'b0, 1'b0, 1'b0, D_NONE);
		endcase
		return o;
	endfunction

endpackage

>>> rtl/core/rtnh_mac.sv
// Serial signed multiply-accumulate: one multiplier bit per cycle, LSB first.
module rtnh_mac
	import rtnh_pkg::*;
#(
	parameter int NW = COORD_W_DEF + 1,
	parameter int AW = 3 * COORD_W_DEF + 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mac_ctl_t             ctl,
	input  logic signed [AW-1:0] mcand,
	input  logic signed [NW-1:0] mplier,
	output logic signed [AW-1:0] acc,
	output logic                 busy
);

	localparam int CNT_W = $clog2(NW);

	logic signed [AW-1:0] m_q;
	logic        [NW-1:0] b_q;
	logic signed [AW-1:0] acc_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 neg_q;
	logic                 last_bit;

	// the top multiplier bit carries negative weight
	assign last_bit = (cnt_q == CNT_W'(NW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			neg_q  <= ctl.negate;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last_bit) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath: shifted multiplicand, multiplier bits, accumulator
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			m_q <= mcand;
			b_q <= mplier;
			if (ctl.clear) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			m_q <= m_q <<< 1;
			b_q <= b_q >> 1;
			if (b_q[0]) begin
				if (last_bit ^ neg_q) begin
					acc_q <= acc_q - m_q;
				end else begin
					acc_q <= acc_q + m_q;
				end
			end
		end
	end

	assign acc  = acc_q;
	assign busy = busy_q;

endmodule

>>> rtl/core/ray_triangle_nearest_hit.sv
// Nearest ray/triangle hit search with an exact integer Moller-Trumbore test.
// Input channel s_*: tuser is the command (0 load ray, 1 test triangle);
// tdata carries nine signed Q16.16 coordinates. A load stores origin (a) and
// direction (b) and clears the nearest-hit state. A test checks the triangle
// a, b, c against the stored ray.
// Output channel m_*: one result per request with the hit flag, the hit
// distance, the nearest distance since the last load and the found flag.
// Flow: a load passes from acceptance through FINISH to the output register.
// A test runs 24 serial multiply-accumulate steps, each of COORD_WIDTH+1
// multiplier bits plus start, wait and store, on one shared adder, then a
// restoring divide, and returns to idle through FINISH before the next
// request. Rejected triangles skip the divide.
// One request is in flight at a time; s_tready is high only while idle.
// Reset clears the ray to zero, the nearest distance to all ones and the
// found flag. A stalled receiver holds the result in the output register
// and a later result waits in FINISH until that register is free.
module ray_triangle_nearest_hit
	import rtnh_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_W_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// ax, ay, az, bx, by_coord, bz, cx, cy, cz; 32 bits each from bit 0
	input  logic [9*IN_W-1:0]   s_tdata,
	// command
	input  logic                s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// hit[0], hit_distance[31:1], nearest_distance[62:32], any_found[63]
	output logic [63:0]         m_tdata
);

	localparam int W   = COORD_WIDTH;
	localparam int NW  = W + 1;
	localparam int CW  = 2 * W + 3;
	localparam int AW  = 3 * W + 6;
	localparam int DVW = AW + QUOT_W - 1;

	typedef enum logic [2:0] {
		S_IDLE, S_MUL_GO, S_MUL_WAIT, S_MUL_NEXT, S_CHECK, S_DIV, S_FINISH
	} state_t;

	state_t state_q;

	logic signed [NW-1:0] nv_q [4][3];
	logic signed [W-1:0]  org_q [3];
	logic signed [CW-1:0] pv_q [3];
	logic signed [CW-1:0] qv_q [3];
	logic signed [AW-1:0] det_q, un_q, vn_q, tn_q;
	logic                 det_neg_q;
	logic [4:0]           op_q;
	logic                 load_q;
	logic                 pass_q;
	logic [DVW-1:0]       rem_q, dsh_q;
	logic [QUOT_W-1:0]    quo_q;
	logic [4:0]           dcnt_q;
	logic [DIST_W-1:0]    nearest_q;
	logic                 found_q;

	logic                 hit_q, any_q;
	logic [DIST_W-1:0]    hdist_q, ndist_q;
	logic                 mvalid_q;

	op_t                  op;
	mac_ctl_t             mac_ctl;
	logic signed [AW-1:0] mcand, acc;
	logic signed [NW-1:0] mplier;
	logic                 mac_busy;
	logic signed [W-1:0]  in_c [9];
	logic signed [AW:0]   uv_sum;
	logic                 pass;
	logic [DIST_W-1:0]    t_val;
	logic                 t_ok;
	logic                 out_free;

	// unpack input coordinates at the configured width
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			in_c[k] = s_tdata[k*IN_W +: W];
		end
	end

	// operand selection for the current step
	assign op = op_decode(op_q);

	always_comb begin
		unique case (op.wsel)
			V_PV:    mcand = AW'(pv_q[op.wi]);
			V_QV:    mcand = AW'(qv_q[op.wi]);
			default: mcand = AW'(nv_q[op.wsel[1:0]][op.wi]);
		endcase
		mplier          = nv_q[op.msel[1:0]][op.mi];
		mac_ctl.start   = (state_q == S_MUL_GO);
		mac_ctl.clear   = op.first;
		mac_ctl.negate  = op.sub ^ (det_neg_q && (op_q >= FIRST_DOT_NEG));
	end

	rtnh_mac #(.NW(NW), .AW(AW)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.mcand  (mcand),
		.mplier (mplier),
		.acc    (acc),
		.busy   (mac_busy)
	);

	// barycentric, det and t-sign checks
	always_comb begin
		uv_sum = {un_q[AW-1], un_q} + {vn_q[AW-1], vn_q};
		pass = (det_q >= $signed({1'b0, (AW-1)'(DET_MIN)}))
			&& !un_q[AW-1] && (un_q <= det_q)
			&& !vn_q[AW-1] && (uv_sum <= {det_q[AW-1], det_q})
			&& !tn_q[AW-1] && (tn_q != '0);
	end

	// saturated quotient and near-t test
	assign t_val    = quo_q[QUOT_W-1] ? T_ONES : quo_q[DIST_W-1:0];
	assign t_ok     = pass_q && (t_val >= T_MIN);
	assign out_free = !mvalid_q || m_tready;

	// sequencer with registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= '0;
			load_q    <= 1'b0;
			pass_q    <= 1'b0;
			det_neg_q <= 1'b0;
			dcnt_q    <= '0;
			nearest_q <= T_ONES;
			found_q   <= 1'b0;
			mvalid_q  <= 1'b0;
			for (int v = 0; v < 4; v++) begin
				for (int k = 0; k < 3; k++) begin
					nv_q[v][k] <= '0;
				end
			end
			for (int k = 0; k < 3; k++) begin
				org_q[k] <= '0;
			end
		end else begin
			// FINISH reloads the output register itself
			if (mvalid_q && m_tready && state_q != S_FINISH) begin
				mvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q   <= '0;
						pass_q <= 1'b0;
						if (s_tuser == CMD_LOAD) begin
							load_q <= 1'b1;
							for (int k = 0; k < 3; k++) begin
								org_q[k]            <= in_c[k];
								nv_q[2'(V_DIR)][k] <= NW'(in_c[3+k]);
							end
							state_q <= S_FINISH;
						end else begin
							load_q <= 1'b0;
							for (int k = 0; k < 3; k++) begin
								nv_q[2'(V_E1)][k] <= NW'(in_c[3+k]) - NW'(in_c[k]);
								nv_q[2'(V_E2)][k] <= NW'(in_c[6+k]) - NW'(in_c[k]);
								nv_q[2'(V_TV)][k] <= NW'(org_q[k]) - NW'(in_c[k]);
							end
							state_q <= S_MUL_GO;
						end
					end
				end
				S_MUL_GO: begin
					state_q <= S_MUL_WAIT;
				end
				S_MUL_WAIT: begin
					if (!mac_busy) begin
						state_q <= S_MUL_NEXT;
					end
				end
				S_MUL_NEXT: begin
					if (op.dest == D_DET) begin
						det_neg_q <= acc[AW-1];
					end
					op_q <= op_q + 1'b1;
					if (op_q == LAST_OP) begin
						state_q <= S_CHECK;
					end else begin
						state_q <= S_MUL_GO;
					end
				end
				S_CHECK: begin
					pass_q  <= pass;
					dcnt_q  <= '0;
					state_q <= pass ? S_DIV : S_FINISH;
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 5'(QUOT_W - 1)) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						mvalid_q <= 1'b1;
						if (load_q) begin
							nearest_q <= T_ONES;
							found_q   <= 1'b0;
						end else if (t_ok && (t_val < nearest_q)) begin
							nearest_q <= t_val;
							found_q   <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// product stores and divider datapath
	always_ff @(posedge clk) begin
		if (state_q == S_MUL_NEXT) begin
			unique case (op.dest)
				D_PV0: pv_q[0] <= acc[CW-1:0];
				D_PV1: pv_q[1] <= acc[CW-1:0];
				D_PV2: pv_q[2] <= acc[CW-1:0];
				D_QV0: qv_q[0] <= acc[CW-1:0];
				D_QV1: qv_q[1] <= acc[CW-1:0];
				D_QV2: qv_q[2] <= acc[CW-1:0];
				D_DET: det_q <= acc[AW-1] ? -acc : acc;
				D_UN:  un_q <= acc;
				D_VN:  vn_q <= acc;
				D_TN:  tn_q <= acc;
				default: ;
			endcase
		end
		if (state_q == S_CHECK) begin
			rem_q <= DVW'({tn_q, 16'b0});
			dsh_q <= DVW'(det_q) << (QUOT_W - 1);
			quo_q <= '0;
		end else if (state_q == S_DIV) begin
			dsh_q <= dsh_q >> 1;
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[QUOT_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QUOT_W-2:0], 1'b0};
			end
		end
		if (state_q == S_FINISH && out_free) begin
			hit_q   <= t_ok;
			hdist_q <= t_ok ? t_val : '0;
			if (load_q) begin
				ndist_q <= T_ONES;
				any_q   <= 1'b0;
			end else if (t_ok && (t_val < nearest_q)) begin
				ndist_q <= t_val;
				any_q   <= 1'b1;
			end else begin
				ndist_q <= nearest_q;
				any_q   <= found_q;
			end
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = mvalid_q;
	assign m_tdata  = {any_q, ndist_q, hdist_q, hit_q};

	// a reported hit always clears the near-t floor
	a_hit_floor: assert property (@(posedge clk) disable iff (!arst_n)
		mvalid_q && hit_q |-> hdist_q >= T_MIN)
		else $error("hit reported below minimum distance");

	// found flag means a real nearest distance
	a_found_dist: assert property (@(posedge clk) disable iff (!arst_n)
		mvalid_q && any_q |-> ndist_q != T_ONES)
		else $error("found flag with empty nearest distance");

	// nearest never exceeds the current hit
	a_nearest_le: assert property (@(posedge clk) disable iff (!arst_n)
		mvalid_q && hit_q |-> ndist_q <= hdist_q)
		else $error("nearest distance above current hit");

	// the multiplier is only started when idle
	a_mac_start: assert property (@(posedge clk) disable iff (!arst_n)
		mac_ctl.start |-> !mac_busy)
		else $error("multiplier restarted while busy");

endmodule
